@@ rtl/kear_pkg.sv @@
// ----------------------------------------------------------------------------
// kear_pkg
// Shared types and constants for the key event auto-repeat scanner.
// ----------------------------------------------------------------------------
package kear_pkg;

    localparam int KEY_LEVELS_W = 5;
    localparam int KEY_W        = 3;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int DPI_W        = CFG_W + 1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd500;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        KIND_DOWN   = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_UP     = 2'd2
    } kind_t;

    typedef struct packed {
        logic enable;
    } scan_t;

    typedef struct packed {
        logic  fire;
        kind_t kind;
    } cell_evt_t;

endpackage

@@ rtl/kear_cell.sv @@
// ----------------------------------------------------------------------------
// kear_cell
// One key of the scan chain: held flag, press time and event decision.
// ----------------------------------------------------------------------------
module kear_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kear_pkg::scan_t                scan_in,
    input  logic                           level,
    input  logic [kear_pkg::TIME_W-1:0]    now_ms,
    input  logic [kear_pkg::CFG_W-1:0]     interval,
    input  logic [kear_pkg::DPI_W-1:0]     dpi,
    output kear_pkg::scan_t                scan_out,
    output kear_pkg::cell_evt_t            evt
);

    logic                        held_reg;
    logic                        held_next;
    logic [kear_pkg::TIME_W-1:0] press_time_reg;
    logic [kear_pkg::TIME_W-1:0] press_time_next;
    logic [kear_pkg::TIME_W-1:0] elapsed;
    logic                        claim;
    logic                        repeat_due;

    assign elapsed    = now_ms - press_time_reg;
    assign repeat_due = elapsed > {{(kear_pkg::TIME_W-kear_pkg::DPI_W){1'b0}}, dpi};
    assign claim      = level | held_reg;

    assign scan_out.enable = scan_in.enable & ~claim;

    always_comb
    begin
        held_next       = held_reg;
        press_time_next = press_time_reg;
        evt.fire        = 1'b0;
        evt.kind        = kear_pkg::KIND_DOWN;
        if (scan_in.enable)
        begin
            if (level && !held_reg)
            begin
                held_next       = 1'b1;
                press_time_next = now_ms;
                evt.fire        = 1'b1;
                evt.kind        = kear_pkg::KIND_DOWN;
            end
            else if (level && repeat_due)
            begin
                press_time_next = press_time_reg
                                + {{(kear_pkg::TIME_W-kear_pkg::CFG_W){1'b0}}, interval};
                evt.fire        = 1'b1;
                evt.kind        = kear_pkg::KIND_REPEAT;
            end
            else if (!level && held_reg)
            begin
                held_next = 1'b0;
                evt.fire  = 1'b1;
                evt.kind  = kear_pkg::KIND_UP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_time_reg <= press_time_next;
    end

endmodule

@@ rtl/key_event_autorepeat_scanner_top.sv @@
// ----------------------------------------------------------------------------
// key_event_autorepeat_scanner_top
// Five-key typematic scanner with a one-entry event slot and output register.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle, set by the combinational scan of the
//   cell row and the output register, while out_ready stays high
// reset: slot empty, all keys released, delay 500 ms, interval 100 ms
// press times are not reset; they are only read once a key is held
module key_event_autorepeat_scanner_top #(
    parameter int NUM_KEYS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [kear_pkg::KEY_LEVELS_W-1:0]   key_levels,
    input  logic [kear_pkg::TIME_W-1:0]         now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                event_valid,
    output logic [kear_pkg::KEY_W-1:0]          event_key,
    output logic [1:0]                          event_kind,
    output logic                                pending,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kear_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kear_pkg::CFG_W-1:0]          cfg_data
);

    logic [kear_pkg::CFG_W-1:0]  delay_reg;
    logic [kear_pkg::CFG_W-1:0]  delay_next;
    logic [kear_pkg::CFG_W-1:0]  interval_reg;
    logic [kear_pkg::CFG_W-1:0]  interval_next;
    logic [kear_pkg::DPI_W-1:0]  dpi_reg;
    logic [kear_pkg::DPI_W-1:0]  dpi_next;

    logic                        slot_full_reg;
    logic                        slot_full_next;
    logic [kear_pkg::KEY_W-1:0]  slot_key_reg;
    logic [kear_pkg::KEY_W-1:0]  slot_key_next;
    kear_pkg::kind_t             slot_kind_reg;
    kear_pkg::kind_t             slot_kind_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        event_valid_reg;
    logic                        event_valid_next;
    logic [kear_pkg::KEY_W-1:0]  event_key_reg;
    logic [kear_pkg::KEY_W-1:0]  event_key_next;
    kear_pkg::kind_t             event_kind_reg;
    kear_pkg::kind_t             event_kind_next;
    logic                        pending_reg;
    logic                        pending_next;

    logic                        in_take;
    logic                        cfg_take;
    logic                        poll_take;

    kear_pkg::scan_t             scan [NUM_KEYS+1];
    kear_pkg::cell_evt_t         cell_evt [NUM_KEYS];
    logic [NUM_KEYS-1:0]         cell_level;

    logic                        hit_fire;
    logic [kear_pkg::KEY_W-1:0]  hit_key;
    kear_pkg::kind_t             hit_kind;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_take   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid & cfg_ready;
    assign poll_take = in_take & (cmd == kear_pkg::CMD_POLL) & ~slot_full_reg;

    assign scan[0].enable = poll_take;

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++)
        begin : g_cell
            if (g < kear_pkg::KEY_LEVELS_W)
            begin : g_lvl
                assign cell_level[g] = key_levels[g];
            end
            else
            begin : g_none
                assign cell_level[g] = 1'b0;
            end

            kear_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .scan_in  (scan[g]),
                .level    (cell_level[g]),
                .now_ms   (now_ms),
                .interval (interval_reg),
                .dpi      (dpi_reg),
                .scan_out (scan[g+1]),
                .evt      (cell_evt[g])
            );
        end
    endgenerate

    // only one cell can fire, so the loop simply takes the firing cell's event
    always_comb
    begin
        hit_fire = 1'b0;
        hit_key  = '0;
        hit_kind = kear_pkg::KIND_DOWN;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (cell_evt[i].fire)
            begin
                hit_fire = 1'b1;
                hit_key  = kear_pkg::KEY_W'(i);
                hit_kind = cell_evt[i].kind;
            end
        end
    end

    // configuration
    always_comb
    begin
        delay_next    = delay_reg;
        interval_next = interval_reg;
        if (cfg_take)
        begin
            unique case (cfg_index)
                kear_pkg::CFG_DELAY:    delay_next    = cfg_data;
                kear_pkg::CFG_INTERVAL: interval_next = cfg_data;
                default:
                begin
                end
            endcase
        end
        dpi_next = {1'b0, delay_next} + {1'b0, interval_next};
    end

    // slot and result register
    always_comb
    begin
        slot_full_next   = slot_full_reg;
        slot_key_next    = slot_key_reg;
        slot_kind_next   = slot_kind_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        event_valid_next = event_valid_reg;
        event_key_next   = event_key_reg;
        event_kind_next  = event_kind_reg;
        pending_next     = pending_reg;
        if (in_take)
        begin
            out_valid_next = 1'b1;
            if (cmd == kear_pkg::CMD_POP)
            begin
                event_valid_next = slot_full_reg;
                event_key_next   = slot_full_reg ? slot_key_reg : '0;
                event_kind_next  = slot_full_reg ? slot_kind_reg : kear_pkg::KIND_DOWN;
                pending_next     = 1'b0;
                slot_full_next   = 1'b0;
                slot_key_next    = '0;
                slot_kind_next   = kear_pkg::KIND_DOWN;
            end
            else
            begin
                event_valid_next = 1'b0;
                event_key_next   = '0;
                event_kind_next  = kear_pkg::KIND_DOWN;
                if (poll_take && hit_fire)
                begin
                    slot_full_next = 1'b1;
                    slot_key_next  = hit_key;
                    slot_kind_next = hit_kind;
                end
                pending_next = slot_full_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= kear_pkg::DELAY_RESET;
            interval_reg  <= kear_pkg::INTERVAL_RESET;
            dpi_reg       <= {1'b0, kear_pkg::DELAY_RESET} + {1'b0, kear_pkg::INTERVAL_RESET};
            slot_full_reg <= 1'b0;
            slot_key_reg  <= '0;
            slot_kind_reg <= kear_pkg::KIND_DOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delay_reg     <= delay_next;
            interval_reg  <= interval_next;
            dpi_reg       <= dpi_next;
            slot_full_reg <= slot_full_next;
            slot_key_reg  <= slot_key_next;
            slot_kind_reg <= slot_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_valid_reg <= event_valid_next;
        event_key_reg   <= event_key_next;
        event_kind_reg  <= event_kind_next;
        pending_reg     <= pending_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = event_valid_reg;
    assign event_key   = event_key_reg;
    assign event_kind  = event_kind_reg;
    assign pending     = pending_reg;

endmodule

@@ rtl/kear_checker.sv @@
// ----------------------------------------------------------------------------
// kear_checker
// Port-level checks for the key event auto-repeat scanner.
// ----------------------------------------------------------------------------
module kear_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                event_valid,
    input  logic [kear_pkg::KEY_W-1:0]          event_key,
    input  logic [1:0]                          event_kind,
    input  logic                                pending
);

    // stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // every transaction yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result");

    // a popped event leaves the slot empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |-> !pending)
        else $error("pending after pop");

    // no event means zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> event_key == '0 && event_kind == kear_pkg::KIND_DOWN)
        else $error("stray event fields");

    // popped events name a real key and kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |->
            event_key < kear_pkg::KEY_W'(kear_pkg::KEY_LEVELS_W)
            && event_kind <= kear_pkg::KIND_UP)
        else $error("bad event code");

endmodule

bind key_event_autorepeat_scanner_top kear_checker u_kear_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_valid (event_valid),
    .event_key   (event_key),
    .event_kind  (event_kind),
    .pending     (pending)
);

@@ dv/key_event_autorepeat_scanner_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_autorepeat_scanner_top_tb
// Drives poll and pop transactions into the typematic scanner and tracks
// key-held state, press times and the event slot alongside it. Each result
// is compared field by field. Runs go through several repeat delay and
// interval settings, with random idling on both channels and a long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module key_event_autorepeat_scanner_top_tb;

    localparam int KEY_COUNT      = 5;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 205;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [kear_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [kear_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                              cmd;
        logic [kear_pkg::KEY_LEVELS_W-1:0] levels;
        logic [kear_pkg::TIME_W-1:0]       now;
    } scan_req_t;

    typedef struct packed {
        logic                       ev_valid;
        logic [kear_pkg::KEY_W-1:0] key;
        kear_pkg::kind_t            kind;
        logic                       pending;
    } key_event_t;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic                              cmd        = kear_pkg::CMD_POLL;
    logic [kear_pkg::KEY_LEVELS_W-1:0] key_levels = '0;
    logic [kear_pkg::TIME_W-1:0]       now_ms     = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic                              event_valid;
    logic [kear_pkg::KEY_W-1:0]        event_key;
    logic [1:0]                        event_kind;
    logic                              pending;
    logic                              cfg_valid  = 1'b0;
    logic                              cfg_ready;
    logic [kear_pkg::CFG_INDEX_W-1:0]  cfg_index  = kear_pkg::CFG_DELAY;
    logic [kear_pkg::CFG_W-1:0]        cfg_data   = '0;

    // scanner state as the testbench expects it
    logic [kear_pkg::CFG_W-1:0]        delay_q    = kear_pkg::DELAY_RESET;
    logic [kear_pkg::CFG_W-1:0]        interval_q = kear_pkg::INTERVAL_RESET;
    logic                              slot_full_q = 1'b0;
    logic [kear_pkg::KEY_W-1:0]        slot_key_q  = '0;
    kear_pkg::kind_t                   slot_kind_q = kear_pkg::KIND_DOWN;
    logic [KEY_COUNT-1:0]              held_q      = '0;
    logic [kear_pkg::TIME_W-1:0]       press_q [KEY_COUNT];

    scan_req_t   scan_requests[$];
    key_event_t  expected_events[$];
    scan_req_t   next_req;
    key_event_t  seen_event;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned idle_cycles    = 0;
    int unsigned mismatches     = 0;
    int unsigned queued_items   = 0;
    logic [kear_pkg::TIME_W-1:0] now_cursor = '0;

    key_event_autorepeat_scanner_top #(
        .NUM_KEYS (KEY_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key_levels  (key_levels),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_valid (event_valid),
        .event_key   (event_key),
        .event_kind  (event_kind),
        .pending     (pending),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void post_slot(input int unsigned k, input kear_pkg::kind_t kind);
        slot_full_q = 1'b1;
        slot_key_q  = kear_pkg::KEY_W'(k);
        slot_kind_q = kind;
    endfunction

    // advances the scanner state by one transaction and returns its result
    function automatic key_event_t next_key_event(input scan_req_t req);
        key_event_t                  res;
        logic                        done;
        logic [kear_pkg::TIME_W-1:0] elapsed;
        logic [kear_pkg::TIME_W-1:0] repeat_after;
        res = '0;
        res.kind = kear_pkg::KIND_DOWN;
        done = 1'b0;
        if (req.cmd == kear_pkg::CMD_POLL)
        begin
            if (!slot_full_q)
            begin
                repeat_after = kear_pkg::TIME_W'(delay_q) + kear_pkg::TIME_W'(interval_q);
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    if (!done)
                    begin
                        if (req.levels[k])
                        begin
                            if (!held_q[k])
                            begin
                                held_q[k]  = 1'b1;
                                press_q[k] = req.now;
                                post_slot(k, kear_pkg::KIND_DOWN);
                            end
                            else
                            begin
                                elapsed = req.now - press_q[k];
                                if (elapsed > repeat_after)
                                begin
                                    press_q[k] = press_q[k]
                                               + kear_pkg::TIME_W'(interval_q);
                                    post_slot(k, kear_pkg::KIND_REPEAT);
                                end
                            end
                            done = 1'b1;
                        end
                        else if (held_q[k])
                        begin
                            held_q[k] = 1'b0;
                            post_slot(k, kear_pkg::KIND_UP);
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            if (slot_full_q)
            begin
                res.ev_valid = 1'b1;
                res.key      = slot_key_q;
                res.kind     = slot_kind_q;
            end
            slot_full_q = 1'b0;
            slot_key_q  = '0;
            slot_kind_q = kear_pkg::KIND_DOWN;
        end
        res.pending = slot_full_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= kear_pkg::CMD_POLL;
            key_levels <= '0;
            now_ms     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_events.push_back(next_key_event({cmd, key_levels, now_ms}));
            if (!in_valid || in_ready)
            begin
                if (scan_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = scan_requests.pop_front();
                    cmd        <= next_req.cmd;
                    key_levels <= next_req.levels;
                    now_ms     <= next_req.now;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, armed by bumping hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch("result transaction with nothing expected");
                end
                else
                begin
                    seen_event = expected_events.pop_front();
                    if (event_valid !== seen_event.ev_valid)
                        report_mismatch($sformatf("event_valid got %0b expected %0b",
                                                  event_valid, seen_event.ev_valid));
                    if (event_key !== seen_event.key)
                        report_mismatch($sformatf("event_key got %0d expected %0d",
                                                  event_key, seen_event.key));
                    if (event_kind !== seen_event.kind)
                        report_mismatch($sformatf("event_kind got %0d expected %0d",
                                                  event_kind, seen_event.kind));
                    if (pending !== seen_event.pending)
                        report_mismatch($sformatf("pending got %0b expected %0b",
                                                  pending, seen_event.pending));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("key_event_autorepeat_scanner_top_tb failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void queue_req(input logic c,
                                      input logic [kear_pkg::KEY_LEVELS_W-1:0] lv,
                                      input logic [kear_pkg::TIME_W-1:0] t);
        scan_req_t req;
        req.cmd    = c;
        req.levels = lv;
        req.now    = t;
        scan_requests.push_back(req);
        queued_items++;
    endfunction

    task automatic write_reg(input logic [kear_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [kear_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == kear_pkg::CFG_DELAY)
            delay_q = val;
        else if (idx == kear_pkg::CFG_INTERVAL)
            interval_q = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (scan_requests.size() != 0 || in_valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // reset settings: delay 500, interval 100, repeat after 600 ms held
    task automatic queue_directed();
        logic [kear_pkg::TIME_W-1:0] t0;
        t0 = 32'd1000;
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b00001, t0);
        queue_req(kear_pkg::CMD_POLL, 5'b00000, t0 + 1);
        queue_req(kear_pkg::CMD_POP,  5'b11111, 32'hFFFF_FFFF);
        queue_req(kear_pkg::CMD_POLL, 5'b00001, t0 + 600);
        queue_req(kear_pkg::CMD_POLL, 5'b00001, t0 + 601);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        // held key 0 masks every lower priority key
        queue_req(kear_pkg::CMD_POLL, 5'b11111, t0 + 602);
        queue_req(kear_pkg::CMD_POLL, 5'b11110, t0 + 603);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        // press just before the time wraps, repeat just after
        queue_req(kear_pkg::CMD_POLL, 5'b10000, 32'hFFFF_FFF0);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b10000, 32'h0000_0250);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b10010, 32'h0000_0300);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b10000, 32'h0000_0301);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b00000, 32'h0000_0302);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        // time going backwards reads as a huge elapsed time
        queue_req(kear_pkg::CMD_POLL, 5'b00100, 32'd2000);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b00100, 32'd1999);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
        queue_req(kear_pkg::CMD_POLL, 5'b00000, 32'd2001);
        queue_req(kear_pkg::CMD_POP,  5'b00000, 32'd0);
    endtask

    // press, hold across repeat points, then usually release; most polls are followed by a pop
    task automatic queue_session(input int unsigned d, input int unsigned iv);
        logic [kear_pkg::KEY_LEVELS_W-1:0] lv;
        int unsigned                       polls;
        lv = $urandom_range(1)
           ? kear_pkg::KEY_LEVELS_W'(1 << $urandom_range(KEY_COUNT - 1))
           : kear_pkg::KEY_LEVELS_W'($urandom);
        polls = $urandom_range(1, 8);
        for (int k = 0; k < polls; k++)
        begin
            now_cursor = now_cursor + $urandom_range(0, 2 * (d + iv) + 4);
            if ($urandom_range(9) == 0)
                lv = kear_pkg::KEY_LEVELS_W'($urandom);
            queue_req(kear_pkg::CMD_POLL, lv, now_cursor);
            if ($urandom_range(9) != 0)
                queue_req(kear_pkg::CMD_POP, kear_pkg::KEY_LEVELS_W'($urandom), $urandom);
        end
        if ($urandom_range(9) < 7)
        begin
            for (int k = 0; k <= KEY_COUNT; k++)
            begin
                now_cursor = now_cursor + $urandom_range(0, 3);
                queue_req(kear_pkg::CMD_POLL, '0, now_cursor);
                queue_req(kear_pkg::CMD_POP, kear_pkg::KEY_LEVELS_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic queue_phase(input int unsigned d, input int unsigned iv);
        queued_items = 0;
        while (queued_items < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 4))
                    queue_req(1'($urandom), kear_pkg::KEY_LEVELS_W'($urandom), $urandom);
            end
            else
            begin
                queue_session(d, iv);
            end
        end
    endtask

    initial
    begin
        int unsigned d;
        int unsigned iv;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        wait_drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin d = 0;     iv = 1;     end
                1: begin d = 65535; iv = 65535; end
                2: begin d = 0;     iv = 0;     end
                4: begin d = 1;     iv = 65535; end
                5: begin d = 65535; iv = 0;     end
                7: begin d = 500;   iv = 100;   end
                default:
                begin
                    d  = $urandom_range(0, 800);
                    iv = $urandom_range(1, 300);
                end
            endcase
            if (phase == 4)
            begin
                write_reg(CFG_SPARE_A, kear_pkg::CFG_W'($urandom));
                write_reg(CFG_SPARE_B, kear_pkg::CFG_W'($urandom));
            end
            write_reg(kear_pkg::CFG_DELAY, kear_pkg::CFG_W'(d));
            write_reg(kear_pkg::CFG_INTERVAL, kear_pkg::CFG_W'(iv));
            @(negedge clk);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            now_cursor = (phase == 4) ? 32'hFFFF_F000 : $urandom;
            if (phase == 2 || phase == 6)
                hold_req++;
            queue_phase(d, iv);
            wait_drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("key_event_autorepeat_scanner_top_tb passed");
        else
            $display("key_event_autorepeat_scanner_top_tb failed");
        $finish;
    end

endmodule
